// ----- hdl/rthsv_pkg.sv -----
`timescale 1ns / 1ps

package rthsv_pkg;

    // channel and result widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;

    // long division geometry, shared by hue and saturation
    localparam int NUM_W = 23;
    localparam int DEN_W = 8;
    localparam int QUO_W = 15;

    // degrees times 64
    localparam int HUE_60 = 3840;

    // largest-channel selector, red wins ties, then green
    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } chan_sel_t;

endpackage

// ----- hdl/rthsv_div.sv -----
`timescale 1ns / 1ps

module rthsv_div
    import rthsv_pkg::*;
(
    input  logic             aclk,
    input  logic             ce,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [QUO_W-1:0] quot_out
);

    // numerator must be below den * 2**QUO_W, so the top bits start below den
    logic [DEN_W-1:0] rem_reg  [0:QUO_W-1];
    logic [DEN_W-1:0] rem_next [0:QUO_W-1];
    logic [NUM_W-1:0] num_reg  [0:QUO_W-1];
    logic [NUM_W-1:0] num_next [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg  [0:QUO_W-1];
    logic [DEN_W-1:0] den_next [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg  [0:QUO_W-1];
    logic [QUO_W-1:0] quo_next [0:QUO_W-1];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] num_stage;
            logic [DEN_W-1:0] den_stage;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (k == 0) begin : g_first
                assign rem_in    = num_in[NUM_W-1:QUO_W];
                assign num_stage = num_in;
                assign den_stage = den_in;
                assign quo_in    = '0;
            end else begin : g_rest
                assign rem_in    = rem_reg[k-1];
                assign num_stage = num_reg[k-1];
                assign den_stage = den_reg[k-1];
                assign quo_in    = quo_reg[k-1];
            end

            // shift in one numerator bit, subtract when it fits
            assign trial = {rem_in, num_stage[QUO_W-1-k]};
            assign ge    = (trial >= {1'b0, den_stage});

            always_comb begin
                rem_next[k] = ge ? DEN_W'(trial - {1'b0, den_stage}) : trial[DEN_W-1:0];
                num_next[k] = num_stage;
                den_next[k] = den_stage;
                quo_next[k] = {quo_in[QUO_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k] <= rem_next[k];
                    num_reg[k] <= num_next[k];
                    den_reg[k] <= den_next[k];
                    quo_reg[k] <= quo_next[k];
                end
            end
        end
    endgenerate

    assign quot_out = quo_reg[QUO_W-1];

endmodule

// ----- hdl/rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps
// rgb to hsv pixel converter
// path from input transfer to result: two setup stages
//   and one restoring-division stage per quotient bit (15 bits of hue)
// throughput: one pixel per cycle; a stalled output holds the whole pipeline
// reset: aresetn synchronous active low, clears the stage valid bits only

module rgb_to_hsv_convert
    import rthsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue [14:0], saturation [22:15], brightness [30:23]
);

    // two setup stages, then the division pipeline
    localparam int DEPTH = 2 + QUO_W;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             ce;

    // whole pipeline moves when the output slot is empty or being taken
    assign ce       = ~valid_reg[DEPTH-1] | m_tready;
    assign s_tready = ce;

    always_comb begin
        valid_next = {valid_reg[DEPTH-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: max, min, delta, winning channel and its signed difference
    logic [CHAN_W-1:0] red, green, blue;
    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    logic [CHAN_W-1:0] mx_next, mn_next;
    chan_sel_t         sel_next;
    logic signed [CHAN_W:0] diff_next;

    always_comb begin
        // red first, then green on ties
        if (red >= green && red >= blue) begin
            sel_next  = SEL_RED;
            mx_next   = red;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= blue) begin
            sel_next  = SEL_GREEN;
            mx_next   = green;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sel_next  = SEL_BLUE;
            mx_next   = blue;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next) mn_next = blue;
    end

    logic [CHAN_W-1:0]      s1_mx_reg;
    logic [CHAN_W-1:0]      s1_delta_reg;
    chan_sel_t              s1_sel_reg;
    logic signed [CHAN_W:0] s1_diff_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_mx_reg    <= mx_next;
            s1_delta_reg <= mx_next - mn_next;
            s1_sel_reg   <= sel_next;
            s1_diff_reg  <= diff_next;
        end
    end

    // stage 2: hue numerator = 60deg * (sector*delta + diff), with the
    // red-negative case wrapped by 360deg (six sectors)
    logic [2:0]          sector;
    logic signed [11:0]  inner;
    logic signed [23:0]  hue_prod;
    logic [NUM_W-1:0]    hue_num_next;
    logic [DEN_W-1:0]    hue_den_next;
    logic [NUM_W-1:0]    sat_num_next;
    logic [DEN_W-1:0]    sat_den_next;

    always_comb begin
        case (s1_sel_reg)
            SEL_RED:   sector = s1_diff_reg[CHAN_W] ? 3'd6 : 3'd0;
            SEL_GREEN: sector = 3'd2;
            SEL_BLUE:  sector = 3'd4;
            default:   sector = 3'd0;
        endcase
        inner = $signed({1'b0, 11'(sector) * 11'(s1_delta_reg)}) + 12'(s1_diff_reg);
        hue_prod = 24'(inner) * 24'(HUE_60);
        hue_num_next = hue_prod[NUM_W-1:0];
        // gray pixel: numerator is already zero, keep the divisor nonzero
        hue_den_next = (s1_delta_reg == '0) ? DEN_W'(1) : s1_delta_reg;
        // 255*delta as a shift and subtract
        sat_num_next = NUM_W'({s1_delta_reg, 8'd0} - {8'd0, s1_delta_reg});
        sat_den_next = (s1_mx_reg == '0) ? DEN_W'(1) : s1_mx_reg;
    end

    logic [NUM_W-1:0]  s2_hue_num_reg;
    logic [DEN_W-1:0]  s2_hue_den_reg;
    logic [NUM_W-1:0]  s2_sat_num_reg;
    logic [DEN_W-1:0]  s2_sat_den_reg;
    logic [CHAN_W-1:0] s2_mx_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_hue_num_reg <= hue_num_next;
            s2_hue_den_reg <= hue_den_next;
            s2_sat_num_reg <= sat_num_next;
            s2_sat_den_reg <= sat_den_next;
            s2_mx_reg      <= s1_mx_reg;
        end
    end

    // division pipelines, one quotient bit per stage
    logic [QUO_W-1:0] hue_quot;
    logic [QUO_W-1:0] sat_quot;

    rthsv_div u_hue_div (
        .aclk     (aclk),
        .ce       (ce),
        .num_in   (s2_hue_num_reg),
        .den_in   (s2_hue_den_reg),
        .quot_out (hue_quot)
    );

    rthsv_div u_sat_div (
        .aclk     (aclk),
        .ce       (ce),
        .num_in   (s2_sat_num_reg),
        .den_in   (s2_sat_den_reg),
        .quot_out (sat_quot)
    );

    // brightness rides alongside the dividers
    logic [CHAN_W-1:0] bright_reg [0:QUO_W-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            bright_reg[0] <= s2_mx_reg;
            for (int i = 1; i < QUO_W; i++) begin
                bright_reg[i] <= bright_reg[i-1];
            end
        end
    end

    // output transfer
    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {1'b0, bright_reg[QUO_W-1], sat_quot[CHAN_W-1:0], hue_quot[HUE_W-1:0]};

endmodule
